### design/pggv_pkg.sv
// ----------------------------------------------------------------------------
// pggv_pkg
// Shared widths, codes and constants of the periodic grid gradient block.
// ----------------------------------------------------------------------------
package pggv_pkg;

  localparam int MAX_GRID_DIM = 32;

  localparam int OP_W      = 2;
  localparam int CIDX_W    = 4;
  localparam int POS_W     = 5;
  localparam int VALUE_W   = 32;
  localparam int OUT_W     = 48;
  localparam int GRID_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_COEF       = 12;
  localparam int COEF_LEN_BASE  = 9;

  // exact sum carries 25 more fraction bits than the result
  localparam int RND_SHIFT = 25;
  localparam int RND_BIAS  = 1 << (RND_SHIFT - 1);

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD_COEF   = 2'd0;
  localparam op_t OP_LOAD_ENERGY = 2'd1;
  localparam op_t OP_QUERY       = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_SIZE_A = 2'd0;
  localparam cfg_idx_t CFG_GRID_SIZE_B = 2'd1;
  localparam cfg_idx_t CFG_GRID_SIZE_C = 2'd2;

  localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 6'd32;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

### design/pggv_if.sv
// ----------------------------------------------------------------------------
// pggv_if
// Handshake channels of the periodic grid gradient block: input words,
// result words and configuration writes.
// ----------------------------------------------------------------------------
interface pggv_in_if;
  logic                                valid;
  logic                                ready;
  logic [pggv_pkg::OP_W-1:0]           op;
  logic [pggv_pkg::CIDX_W-1:0]         coef_index;
  logic [pggv_pkg::POS_W-1:0]          pos_a;
  logic [pggv_pkg::POS_W-1:0]          pos_b;
  logic [pggv_pkg::POS_W-1:0]          pos_c;
  logic signed [pggv_pkg::VALUE_W-1:0] value;

  modport source (output valid, op, coef_index, pos_a, pos_b, pos_c, value, input ready);
  modport sink   (input valid, op, coef_index, pos_a, pos_b, pos_c, value, output ready);
endinterface

interface pggv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pggv_pkg::OUT_W-1:0] vel_axis_a;
  logic signed [pggv_pkg::OUT_W-1:0] vel_axis_b;
  logic signed [pggv_pkg::OUT_W-1:0] vel_axis_c;
  logic signed [pggv_pkg::OUT_W-1:0] vel_x;
  logic signed [pggv_pkg::OUT_W-1:0] vel_y;
  logic signed [pggv_pkg::OUT_W-1:0] vel_z;
  logic        [pggv_pkg::OUT_W-1:0] speed;
  logic                              status;

  modport source (output valid, vel_axis_a, vel_axis_b, vel_axis_c, vel_x, vel_y, vel_z,
                  speed, status, input ready);
  modport sink   (input valid, vel_axis_a, vel_axis_b, vel_axis_c, vel_x, vel_y, vel_z,
                  speed, status, output ready);
endinterface

interface pggv_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pggv_pkg::CFG_IDX_W-1:0]     index;
  logic [pggv_pkg::GRID_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/periodic_grid_gradient_velocity.sv
// ----------------------------------------------------------------------------
// periodic_grid_gradient_velocity
// Periodic central-difference gradient, Cartesian velocity and speed on a
// loaded 3-D energy grid, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
// Coefficient and energy loads are written from a single accepted word. A query with
// a coordinate outside the configured grid goes straight to the output step and
// returns a flagged word. A good query runs the six neighbour reads from the
// single-port energy memory, the scaling of the differences by the grid size,
// the products and rounding on the shared 41x25 multiplier, the squares and
// the one-bit-a-step square root. The block takes no new word while a query is
// in progress; a finished word waits in the output register.
module periodic_grid_gradient_velocity #(
  parameter int MaxGridDim = pggv_pkg::MAX_GRID_DIM
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pggv_in_if.sink     in_i,
  pggv_out_if.source  out_o,
  pggv_cfg_if.sink    cfg_i
);

  localparam int Depth = MaxGridDim * MaxGridDim * MaxGridDim;
  localparam int AW    = $clog2(Depth);
  localparam int GW    = pggv_pkg::GRID_W;
  localparam int PW    = pggv_pkg::POS_W;
  localparam int OW    = pggv_pkg::OUT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIFF, S_MAC, S_RND, S_SQ, S_SQRT, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [5:0] step_q, step_d;
  logic [2:0] o_q, o_d;
  logic [1:0] k_q, k_d;
  logic       h_q, h_d;
  logic       bad_q, bad_d;

  logic [GW-1:0] grid_q [3];
  logic [pggv_pkg::VALUE_W-1:0] coef_q [pggv_pkg::NUM_COEF];

  logic [PW-1:0] pos_q [3], pos_d [3];
  logic [GW-1:0] n_q [3], n_d [3];
  logic signed [31:0] ep_q, ep_d;
  logic signed [32:0] diff_q [3], diff_d [3];
  logic signed [38:0] de_q [3], de_d [3];
  logic signed [71:0] acc_q, acc_d;
  logic signed [OW-1:0] res_q [6], res_d [6];
  logic [95:0] sq_q, sq_d;
  logic [49:0] rem_q, rem_d;
  logic [47:0] root_q, root_d;

  logic out_valid_q;
  logic signed [OW-1:0] out_res_q [6];
  logic [OW-1:0] out_speed_q;
  logic out_status_q;
  logic out_load;

  logic [31:0] mem_q [Depth];
  logic signed [31:0] rd_data_q;
  logic mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] mul_p;

  logic in_acc;
  logic [PW-1:0] in_pos [3];
  logic [GW-1:0] eff_n [3];
  logic [GW-1:0] pn [3], qn [3], crd [3];
  logic [3:0] cidx;
  logic [1:0] de_idx;
  logic [2:0] vel_idx;
  logic last_term;
  logic [31:0] cval;
  logic signed [71:0] prod_ext, rnd_sum;
  logic [47:0] mag;
  logic [95:0] sq_add;
  logic [51:0] rem_sh, trial;
  logic [2:0] cap_idx;

  function automatic logic [AW-1:0] addr_of(input logic [GW-1:0] a, input logic [GW-1:0] b,
                                            input logic [GW-1:0] c);
    return AW'((32'(a) * MaxGridDim + 32'(b)) * MaxGridDim + 32'(c));
  endfunction

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_pos[0] = in_i.pos_a;
  assign in_pos[1] = in_i.pos_b;
  assign in_pos[2] = in_i.pos_c;

  // grid sizes beyond MaxGridDim clamp to MaxGridDim, the store size per dimension
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      eff_n[d] = (int'(grid_q[d]) > MaxGridDim) ? GW'(MaxGridDim) : grid_q[d];
      pn[d] = ({1'b0, pos_q[d]} == n_q[d] - 6'd1) ? '0 : {1'b0, pos_q[d]} + 6'd1;
      qn[d] = (pos_q[d] == '0) ? n_q[d] - 6'd1 : {1'b0, pos_q[d]} - 6'd1;
      crd[d] = {1'b0, pos_q[d]};
      if (d == int'(step_q[2:1])) crd[d] = step_q[0] ? qn[d] : pn[d];
    end
  end

  assign mem_we  = in_acc && (in_i.op == pggv_pkg::OP_LOAD_ENERGY) &&
                   (int'(in_i.pos_a) < MaxGridDim) && (int'(in_i.pos_b) < MaxGridDim) &&
                   (int'(in_i.pos_c) < MaxGridDim);
  assign wr_addr = addr_of({1'b0, in_i.pos_a}, {1'b0, in_i.pos_b}, {1'b0, in_i.pos_c});
  assign mem_re  = (state_q == S_READ) && (step_q < 6'd6);
  assign rd_addr = addr_of(crd[0], crd[1], crd[2]);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= in_i.value;
    if (mem_re) rd_data_q <= mem_q[rd_addr];
  end

  // operand selection for the shared multiplier
  assign last_term = (o_q < 3'd3) || (k_q == 2'd2);
  assign de_idx    = (o_q < 3'd3) ? o_q[1:0] : k_q;
  assign cidx      = (o_q < 3'd3) ? 4'(pggv_pkg::COEF_LEN_BASE + int'(o_q))
                                  : 4'(int'(k_q) * 3 + int'(o_q) - 3);
  assign cval      = coef_q[cidx];
  assign vel_idx   = 3'd3 + {1'b0, k_q};
  assign mag       = res_q[vel_idx][OW-1] ? 48'(-res_q[vel_idx]) : 48'(res_q[vel_idx]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DIFF: begin
        mul_a = 41'(diff_q[step_q[1:0]]);
        mul_b = $signed({19'b0, n_q[step_q[1:0]]});
      end
      S_MAC: begin
        mul_a = 41'(de_q[de_idx]);
        mul_b = h_q ? 25'($signed(cval[31:16])) : $signed({9'b0, cval[15:0]});
      end
      S_SQ: begin
        mul_a = $signed({17'b0, (step_q == 6'd2) ? mag[47:24] : mag[23:0]});
        mul_b = $signed({1'b0, (step_q == 6'd0) ? mag[23:0] : mag[47:24]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p    = mul_a * mul_b;
  assign prod_ext = 72'(mul_p);
  assign rnd_sum  = acc_q + 72'(pggv_pkg::RND_BIAS);

  always_comb begin
    case (step_q[1:0])
      2'd0:    sq_add = 96'(mul_p[47:0]);
      2'd1:    sq_add = 96'(mul_p[47:0]) << 25;
      default: sq_add = 96'(mul_p[47:0]) << 48;
    endcase
  end

  assign rem_sh  = {rem_q, sq_q[95:94]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign cap_idx = step_q[2:0] - 3'd1;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    o_d     = o_q;
    k_d     = k_q;
    h_d     = h_q;
    bad_d   = bad_q;
    pos_d   = pos_q;
    n_d     = n_q;
    ep_d    = ep_q;
    diff_d  = diff_q;
    de_d    = de_q;
    acc_d   = acc_q;
    res_d   = res_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    root_d  = root_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.op == pggv_pkg::OP_QUERY)) begin
          bad_d = 1'b0;
          for (int d = 0; d < 3; d++) begin
            pos_d[d] = in_pos[d];
            n_d[d]   = eff_n[d];
            if ({1'b0, in_pos[d]} >= eff_n[d]) bad_d = 1'b1;
          end
          acc_d   = '0;
          step_d  = '0;
          o_d     = '0;
          k_d     = '0;
          h_d     = 1'b0;
          state_d = bad_d ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        // read data is registered, so it is captured in the step after its address
        if (step_q != '0) begin
          if (!cap_idx[0]) ep_d = rd_data_q;
          else diff_d[cap_idx[2:1]] = 33'(ep_q) - 33'(rd_data_q);
        end
        if (step_q == 6'd6) begin
          step_d  = '0;
          state_d = S_DIFF;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      S_DIFF: begin
        de_d[step_q[1:0]] = mul_p[38:0];
        if (step_q == 6'd2) begin
          step_d  = '0;
          state_d = S_MAC;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      S_MAC: begin
        acc_d = acc_q + (h_q ? (prod_ext <<< 16) : prod_ext);
        h_d   = ~h_q;
        if (h_q) begin
          if (last_term) state_d = S_RND;
          else k_d = k_q + 2'd1;
        end
      end
      S_RND: begin
        // exact sum stays below 2^70, so the rounded word never saturates
        res_d[o_q] = OW'(rnd_sum >>> pggv_pkg::RND_SHIFT);
        acc_d = '0;
        k_d   = '0;
        h_d   = 1'b0;
        if (o_q == 3'd5) begin
          step_d  = '0;
          sq_d    = '0;
          state_d = S_SQ;
        end else begin
          o_d     = o_q + 3'd1;
          state_d = S_MAC;
        end
      end
      S_SQ: begin
        sq_d = sq_q + sq_add;
        if (step_q == 6'd2) begin
          step_d = '0;
          if (k_q == 2'd2) begin
            rem_d   = '0;
            root_d  = '0;
            state_d = S_SQRT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      S_SQRT: begin
        sq_d = sq_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = 50'(rem_sh - trial);
          root_d = {root_q[46:0], 1'b1};
        end else begin
          rem_d  = rem_sh[49:0];
          root_d = {root_q[46:0], 1'b0};
        end
        if (step_q == 6'd47) state_d = S_OUT;
        else step_d = step_q + 6'd1;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    n_q    <= n_d;
    ep_q   <= ep_d;
    diff_q <= diff_d;
    de_q   <= de_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      o_q          <= '0;
      k_q          <= '0;
      h_q          <= 1'b0;
      bad_q        <= 1'b0;
      grid_q[0]    <= pggv_pkg::GRID_SIZE_RESET;
      grid_q[1]    <= pggv_pkg::GRID_SIZE_RESET;
      grid_q[2]    <= pggv_pkg::GRID_SIZE_RESET;
      for (int i = 0; i < pggv_pkg::NUM_COEF; i++) coef_q[i] <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 6; i++) out_res_q[i] <= '0;
      out_speed_q  <= '0;
      out_status_q <= pggv_pkg::STATUS_OK;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      o_q     <= o_d;
      k_q     <= k_d;
      h_q     <= h_d;
      bad_q   <= bad_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          pggv_pkg::CFG_GRID_SIZE_A: grid_q[0] <= cfg_i.data;
          pggv_pkg::CFG_GRID_SIZE_B: grid_q[1] <= cfg_i.data;
          pggv_pkg::CFG_GRID_SIZE_C: grid_q[2] <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc && (in_i.op == pggv_pkg::OP_LOAD_COEF) &&
          (int'(in_i.coef_index) < pggv_pkg::NUM_COEF)) begin
        coef_q[in_i.coef_index] <= in_i.value;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        for (int i = 0; i < 6; i++) out_res_q[i] <= bad_q ? '0 : res_q[i];
        out_speed_q  <= bad_q ? '0 : root_q;
        out_status_q <= bad_q ? pggv_pkg::STATUS_BAD : pggv_pkg::STATUS_OK;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.vel_axis_a = out_res_q[0];
  assign out_o.vel_axis_b = out_res_q[1];
  assign out_o.vel_axis_c = out_res_q[2];
  assign out_o.vel_x      = out_res_q[3];
  assign out_o.vel_y      = out_res_q[4];
  assign out_o.vel_z      = out_res_q[5];
  assign out_o.speed      = out_speed_q;
  assign out_o.status     = out_status_q;

  // a new word only ever comes from the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result word raised outside the output step");

  // a flagged word carries nothing but the flag; speed and fields a, x and z are checked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |->
      (out_speed_q == '0 && out_res_q[0] == '0 && out_res_q[3] == '0 && out_res_q[5] == '0))
    else $error("flagged word has non-zero fields");

  // the square root walks exactly 48 digit steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (step_q < 6'd48))
    else $error("square root step count overran");

  // the block holds off new words for the whole of a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input ready during a query");

endmodule
